// ===== design/msnap_pkg.sv =====
// Shared types and constants for the multichannel median snapshot block.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package msnap_pkg;

    // Field widths of the input and result transactions.
    localparam int TYPE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int FW_W     = 10;

    // Number of channels a request type can address, and of result fields.
    localparam int NUM_TYPES = 4;
    localparam int NUM_OUT   = 4;

    // Channel that also serves as the frame tick.
    localparam logic [TYPE_W-1:0] TICK_CHANNEL = 2'd0;

    // Reset value of the snapshot period register.
    localparam logic [FW_W-1:0] SNAP_PERIOD_RESET = 10'd60;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [TYPE_W-1:0]  t_req_type;
    typedef logic [FW_W-1:0]    t_frame;

endpackage

// ===== design/msnap_lane.sv =====
// One channel lane: sample history, fill level and rank-selected current value.
// Depends on msnap_pkg for the sample type.
`timescale 1ns / 1ps

module msnap_lane #(
    parameter int WINDOW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hit,
    input  msnap_pkg::t_count i_count,
    output msnap_pkg::t_count o_value
);

    localparam int FILL_W = $clog2(WINDOW + 1);

    msnap_pkg::t_count r_hist [WINDOW];
    logic [FILL_W-1:0] r_fill;
    msnap_pkg::t_count r_cur;

    msnap_pkg::t_count n_hist [WINDOW];
    logic [FILL_W-1:0] n_fill;
    msnap_pkg::t_count n_cur;
    logic [FILL_W-1:0] rank [WINDOW];
    logic [FILL_W-1:0] target;

    // History after this sample is shifted in, newest first.
    always_comb begin
        n_hist[0] = i_count;
        for (int k = 1; k < WINDOW; k++) begin
            n_hist[k] = r_hist[k-1];
        end
    end

    // Fill level saturates at the window depth.
    always_comb begin
        if (r_fill < FILL_W'(WINDOW)) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // Stable rank of each valid entry; the entry whose rank is fill/2 is picked.
    // Ties are broken by position, so exactly one entry matches the target.
    always_comb begin
        target = n_fill >> 1;
        n_cur  = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i && FILL_W'(j) < n_fill &&
                    (n_hist[j] < n_hist[i] || (n_hist[j] == n_hist[i] && j < i))) begin
                    rank[i] = rank[i] + FILL_W'(1);
                end
            end
            if (FILL_W'(i) < n_fill && rank[i] == target) begin
                n_cur = n_cur | n_hist[i];
            end
        end
    end

    // History needs no reset: only entries below the fill level are read.
    always_ff @(posedge i_clk) begin
        if (i_hit) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cur  <= '0;
        end else if (i_hit) begin
            r_fill <= n_fill;
            r_cur  <= n_cur;
        end
    end

    // Value as it stands after the transaction now being processed.
    assign o_value = i_hit ? n_cur : r_cur;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit |=> (r_fill != '0 && r_fill <= FILL_W'(WINDOW)))
        else $error("lane fill level out of range after a sample");

endmodule

// ===== design/msnap_frame.sv =====
// Frame window register and tick counter that decide when a snapshot goes out.
// Depends on msnap_pkg for the frame width and reset constant.
`timescale 1ns / 1ps

module msnap_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  msnap_pkg::t_frame i_cfg_wdata,
    input  logic              i_tick,
    output logic              o_fire
);

    msnap_pkg::t_frame r_snap_period;
    msnap_pkg::t_frame r_tick;
    msnap_pkg::t_frame n_tick;

    // The counter clears when a snapshot fires, which happens once it reaches the window.
    always_comb begin
        n_tick = r_tick + msnap_pkg::t_frame'(1);
        o_fire = i_tick && (n_tick >= r_snap_period);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_period <= msnap_pkg::SNAP_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_snap_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_tick) begin
            r_tick <= o_fire ? '0 : n_tick;
        end
    end

    a_clear_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> (r_tick == '0))
        else $error("tick counter not cleared after a snapshot");

endmodule

// ===== design/multichannel_median_snapshot.sv =====
// Top level of the multichannel median snapshot block.
// Depends on msnap_pkg, msnap_lane and msnap_frame.
//
//  Channel   | Handshake                  | Payload
//  ----------+----------------------------+---------------------------------------
//  sample in | i_in_valid / o_in_ready    | i_req_type, i_count
//  snapshot  | o_out_valid / i_out_ready  | o_l_value, o_t_value, o_x_value,
//            |                            | o_post_value
//  config    | i_cfg_we (no wait)         | i_cfg_wdata (frame window)
//
// One sample transaction per cycle is sustained unless a held snapshot stalls. A sample
// waits in the input register, where the lane's rank select and the tick compare run,
// and a snapshot is loaded into the output register as that sample moves on.
// Reset is synchronous and active low; it clears fill levels, current values, the
// tick counter and the valid flags, and restores the frame window to 60.
// A held snapshot stalls the input register only when the output register is full.
`timescale 1ns / 1ps

module multichannel_median_snapshot #(
    parameter int WINDOW   = 3,
    parameter int CHANNELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msnap_pkg::t_req_type i_req_type,
    input  msnap_pkg::t_count i_count,
    input  logic              i_cfg_we,
    input  msnap_pkg::t_frame i_cfg_wdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msnap_pkg::t_count o_l_value,
    output msnap_pkg::t_count o_t_value,
    output msnap_pkg::t_count o_x_value,
    output msnap_pkg::t_count o_post_value
);

    logic                  r_in_valid;
    msnap_pkg::t_req_type  r_in_type;
    msnap_pkg::t_count     r_in_count;
    logic                  r_out_valid;
    msnap_pkg::t_count     r_out [msnap_pkg::NUM_OUT];

    logic                  advance;
    logic                  accept;
    logic                  tick;
    logic                  fire;
    msnap_pkg::t_count     snap [msnap_pkg::NUM_OUT];

    // The input register moves on whenever the output register can take a result.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;
    assign tick       = advance && (r_in_type == msnap_pkg::TICK_CHANNEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_type  <= i_req_type;
            r_in_count <= i_count;
        end
    end

    // One lane per channel that a request type can reach; missing channels read zero.
    for (genvar c = 0; c < msnap_pkg::NUM_OUT; c++) begin : g_lane
        if (c < CHANNELS && c < msnap_pkg::NUM_TYPES) begin : g_on
            logic hit;
            assign hit = advance && (r_in_type == msnap_pkg::TYPE_W'(c));
            msnap_lane #(
                .WINDOW (WINDOW)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_hit   (hit),
                .i_count (r_in_count),
                .o_value (snap[c])
            );
        end else begin : g_off
            assign snap[c] = '0;
        end
    end

    msnap_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (tick),
        .o_fire      (fire)
    );

    // Output register: loaded with a snapshot, emptied when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < msnap_pkg::NUM_OUT; k++) begin
                r_out[k] <= snap[k];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_l_value    = r_out[0];
    assign o_t_value    = r_out[1];
    assign o_x_value    = r_out[2];
    assign o_post_value = r_out[3];

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_in_ready) |-> (r_out_valid && !i_out_ready))
        else $error("input register stalled with room at the output");

    a_snapshot_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(r_in_valid && r_in_type == msnap_pkg::TICK_CHANNEL))
        else $error("snapshot raised without a tick channel sample");

endmodule

// ===== bench/msnap_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the multichannel median snapshot block: it watches the sample, snapshot
// and frame window ports, predicts every snapshot and compares it field by field.
// Depends on msnap_pkg.

module msnap_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  msnap_pkg::t_req_type i_req_type,
    input  msnap_pkg::t_count    i_count,
    input  logic                 i_cfg_we,
    input  msnap_pkg::t_frame    i_cfg_wdata,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  msnap_pkg::t_count    i_l_value,
    input  msnap_pkg::t_count    i_t_value,
    input  msnap_pkg::t_count    i_x_value,
    input  msnap_pkg::t_count    i_post_value,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_snapshots
);

    // Depth of each channel's sample history.
    localparam int DEPTH = 3;

    typedef struct packed {
        msnap_pkg::t_count l;
        msnap_pkg::t_count t;
        msnap_pkg::t_count x;
        msnap_pkg::t_count post;
    } t_snap;

    // Predicted state of the block.
    msnap_pkg::t_count history [msnap_pkg::NUM_TYPES][DEPTH];
    int unsigned       fill [msnap_pkg::NUM_TYPES];
    msnap_pkg::t_count filtered [msnap_pkg::NUM_TYPES];
    msnap_pkg::t_frame tick_count;
    msnap_pkg::t_frame snap_period;

    // Snapshots predicted but not yet seen on the output channel.
    t_snap       snapshot_q [$];

    // Element at position n/2 of the sorted history; a is the newest sample.
    function automatic msnap_pkg::t_count rank_select(input msnap_pkg::t_count a,
                                                      input msnap_pkg::t_count b,
                                                      input msnap_pkg::t_count c,
                                                      input int unsigned n);
        msnap_pkg::t_count lo;
        msnap_pkg::t_count hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (n == 1)
            return a;
        if (n == 2)
            return hi;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input msnap_pkg::t_count expv,
                               input msnap_pkg::t_count gotv);
        if (gotv !== expv)
            report_error($sformatf("%s expected %0d, got %0d", name, expv, gotv));
    endtask

    // Shift a sample into its channel, refilter it, and advance the frame tick.
    task automatic apply_sample(input msnap_pkg::t_req_type ch, input msnap_pkg::t_count val);
        t_snap snap;
        history[ch][2] = history[ch][1];
        history[ch][1] = history[ch][0];
        history[ch][0] = val;
        if (fill[ch] < DEPTH)
            fill[ch]++;
        filtered[ch] = rank_select(history[ch][0], history[ch][1], history[ch][2], fill[ch]);
        if (ch == msnap_pkg::TICK_CHANNEL) begin
            tick_count = tick_count + msnap_pkg::t_frame'(1);
            if (tick_count >= snap_period) begin
                tick_count = '0;
                snap = '{filtered[0], filtered[1], filtered[2], filtered[3]};
                snapshot_q = {snapshot_q, snap};
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_snap exp_snap;
        if (!i_rst_n) begin
            for (int c = 0; c < msnap_pkg::NUM_TYPES; c++) begin
                fill[c] = 0;
                filtered[c] = '0;
                for (int d = 0; d < DEPTH; d++)
                    history[c][d] = '0;
            end
            tick_count = '0;
            snap_period = msnap_pkg::SNAP_PERIOD_RESET;
            snapshot_q.delete();
            o_pending <= 0;
        end else begin
            // Retire the oldest expectation against each snapshot transaction.
            if (i_out_valid && i_out_ready) begin
                if (snapshot_q.size() == 0) begin
                    report_error("snapshot arrived with none expected");
                end else begin
                    exp_snap = snapshot_q[0];
                    snapshot_q.delete(0);
                    check_field("l_value", exp_snap.l, i_l_value);
                    check_field("t_value", exp_snap.t, i_t_value);
                    check_field("x_value", exp_snap.x, i_x_value);
                    check_field("post_value", exp_snap.post, i_post_value);
                end
                o_snapshots++;
            end
            if (i_cfg_we)
                snap_period = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                apply_sample(i_req_type, i_count);
            o_pending <= snapshot_q.size();
        end
    end

endmodule

// ===== bench/tb_multichannel_median_snapshot.sv =====
`timescale 1ns / 1ps
// Testbench top for the multichannel median snapshot block: drives samples and frame
// window writes, paces both channels and gives the verdict. Depends on msnap_pkg,
// msnap_checker and the block itself.

module tb_multichannel_median_snapshot;

    // Channel codes of the sample transaction.
    localparam msnap_pkg::t_req_type CH_L    = msnap_pkg::TICK_CHANNEL;
    localparam msnap_pkg::t_req_type CH_T    = 2'd1;
    localparam msnap_pkg::t_req_type CH_X    = 2'd2;
    localparam msnap_pkg::t_req_type CH_POST = 2'd3;

    // Cycles without any transaction before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles allowed for samples still inside the block once nothing is expected.
    localparam int SETTLE_CYCLES  = 4;

    typedef enum int { READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC } t_stall_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    msnap_pkg::t_req_type i_req_type  = '0;
    msnap_pkg::t_count    i_count     = '0;
    logic                 i_cfg_we    = 1'b0;
    msnap_pkg::t_frame    i_cfg_wdata = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    msnap_pkg::t_count    o_l_value;
    msnap_pkg::t_count    o_t_value;
    msnap_pkg::t_count    o_x_value;
    msnap_pkg::t_count    o_post_value;

    int errors;
    int snapshots_pending;
    int snapshots_seen;
    int samples_sent   = 0;
    int settings_used  = 0;
    int burst_left     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    multichannel_median_snapshot u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_count      (i_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_l_value    (o_l_value),
        .o_t_value    (o_t_value),
        .o_x_value    (o_x_value),
        .o_post_value (o_post_value)
    );

    msnap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_count      (i_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_l_value    (o_l_value),
        .i_t_value    (o_t_value),
        .i_x_value    (o_x_value),
        .i_post_value (o_post_value),
        .o_errors     (errors),
        .o_pending    (snapshots_pending),
        .o_snapshots  (snapshots_seen)
    );

    // The receiver switches between stall patterns over stretches of random length.
    t_stall_mode stall_mode = READY_ALWAYS;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            READY_ALWAYS:   i_out_ready <= 1'b1;
            READY_COIN:     i_out_ready <= $urandom_range(0, 1);
            READY_SPARSE:   i_out_ready <= ($urandom_range(0, 7) == 0);
            default:        i_out_ready <= (stall_left[1:0] == 2'd0);
        endcase
    end

    // End the run if no transaction moves on either channel for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one sample until it is taken, then either continue the burst or idle.
    task automatic send_sample(input msnap_pkg::t_req_type ch, input msnap_pkg::t_count val);
        i_in_valid <= 1'b1;
        i_req_type <= ch;
        i_count    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Hold off the sender until every predicted snapshot has been received.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (snapshots_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_snap_period(input msnap_pkg::t_frame value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Extremes, a few tie-prone small values, and otherwise the full range.
    function automatic msnap_pkg::t_count pick_count();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return msnap_pkg::t_count'($urandom_range(0, 3));
            default: return msnap_pkg::t_count'($urandom);
        endcase
    endfunction

    // One frame window setting followed by random samples; tick_pct weights channel L.
    task automatic run_phase(input msnap_pkg::t_frame window, input int n, input int tick_pct);
        msnap_pkg::t_req_type ch;
        set_snap_period(window);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < tick_pct)
                ch = CH_L;
            else
                ch = msnap_pkg::t_req_type'($urandom_range(CH_T, CH_POST));
            send_sample(ch, pick_count());
            if ($urandom_range(0, 149) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill each channel through one, two and three samples under the reset window.
        send_sample(CH_T, 8'd200);
        send_sample(CH_T, 8'd100);
        send_sample(CH_T, 8'd150);
        send_sample(CH_T, 8'd255);
        send_sample(CH_T, 8'd0);
        send_sample(CH_X, 8'h55);
        send_sample(CH_X, 8'hAA);
        send_sample(CH_X, 8'h55);
        send_sample(CH_X, 8'h55);
        send_sample(CH_POST, 8'd255);
        send_sample(CH_POST, 8'd255);
        send_sample(CH_POST, 8'd0);
        send_sample(CH_L, 8'd0);
        send_sample(CH_L, 8'd255);
        send_sample(CH_L, 8'd128);
        send_sample(CH_L, 8'd7);
        wait_drained();

        // A window of one is below the pending tick count, so the first tick fires.
        run_phase(10'd1, 60, 30);
        run_phase(10'd0, 60, 30);
        // The widest window, then a narrow one written while ticks are still counted.
        run_phase(10'd1023, 200, 97);
        run_phase(10'd2, 60, 40);
        repeat (4)
            run_phase(msnap_pkg::t_frame'($urandom_range(3, 12)), 40, 40);
        run_phase(msnap_pkg::SNAP_PERIOD_RESET, 60, 60);

        $display("Covered %0d samples over all four channels, %0d snapshots checked,",
                 samples_sent, snapshots_seen);
        $display("under %0d frame window settings from zero to full scale.", settings_used);
        if (errors == 0 && snapshots_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d snapshots outstanding", errors, snapshots_pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
